[design/assert_macros.svh]
// assertion macros used by the downsampler top
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define RGBDS_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("rgbds assertion failed");

// condition that must never be seen outside reset
`define RGBDS_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("rgbds forbidden condition seen");

`endif

[design/rgbds_pkg.sv]
// shared constants and types for the rgb565 box downsampler
// no dependencies
package rgbds_pkg;

    localparam int unsigned IN_SIZE_DEF = 64;
    localparam int unsigned BLOCK_DEF   = 4;

    localparam int unsigned PIX_W     = 16;
    localparam int unsigned RED_W     = 5;
    localparam int unsigned GREEN_W   = 6;
    localparam int unsigned BLUE_W    = 5;
    localparam int unsigned RED_LSB   = 11;
    localparam int unsigned GREEN_LSB = 5;
    localparam int unsigned BLUE_LSB  = 0;
    localparam int unsigned RED_MAX   = 31;
    localparam int unsigned GREEN_MAX = 63;

    // where a pixel sits relative to its output block
    typedef struct packed {
        logic in_blk;
        logic first_col;
        logic last_col;
        logic first_row;
        logic last_row;
        logic last_blk;
    } pos_info_t;

endpackage

[design/rgb565_box_downsampler_top.sv]
// rgb565 box downsampler top: input register, accumulate stage, average stage
// depends on rgbds_pkg, rgbds_pos, rgbds_acc, rgbds_avg, assert_macros.svh
// one pixel word accepted per cycle unless the output is held; an averaged
// word leaves via the accumulate and average stages; one sum word per column
// rst_n clears position counters and stage valids; no memory clearing pass
`include "assert_macros.svh"

module rgb565_box_downsampler_top #(
    parameter int unsigned IN_SIZE = rgbds_pkg::IN_SIZE_DEF,
    parameter int unsigned BLOCK   = rgbds_pkg::BLOCK_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rgbds_pkg::PIX_W-1:0]   in_pixel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rgbds_pkg::PIX_W-1:0]   out_pixel,
    output logic                          frame_last
);

    localparam int unsigned OUT_SIZE = IN_SIZE / BLOCK;
    localparam int unsigned AREA     = BLOCK * BLOCK;
    localparam int unsigned OW       = $clog2(OUT_SIZE + 1);
    localparam int unsigned RS_W     = $clog2(rgbds_pkg::RED_MAX * AREA + 1);
    localparam int unsigned GS_W     = $clog2(rgbds_pkg::GREEN_MAX * AREA + 1);

    rgbds_pkg::pos_info_t          pos_info;
    logic [OW-1:0]                 pos_ocol;
    logic                          in_fire;
    logic                          s0_valid_reg;
    logic [rgbds_pkg::PIX_W-1:0]   s0_pixel_reg;
    rgbds_pkg::pos_info_t          s0_info_reg;
    logic [OW-1:0]                 s0_ocol_reg;
    logic                          s0_fire;
    logic                          s1_adv;
    logic                          out_adv;
    logic                          sum_valid;
    logic [RS_W-1:0]               red_sum, blue_sum;
    logic [GS_W-1:0]               green_sum;
    logic                          sum_last;

    // a held output word stalls an earlier stage only while the stages after it are full
    assign out_adv  = !out_valid || out_ready;
    assign s1_adv   = !sum_valid || out_adv;
    assign in_ready = !s0_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;
    assign s0_fire  = s0_valid_reg && s1_adv;

    rgbds_pos #(
        .IN_SIZE (IN_SIZE),
        .BLOCK   (BLOCK)
    ) u_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_fire),
        .info  (pos_info),
        .ocol  (pos_ocol)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s0_pixel_reg <= in_pixel;
            s0_info_reg  <= pos_info;
            s0_ocol_reg  <= pos_ocol;
        end
    end

    rgbds_acc #(
        .IN_SIZE (IN_SIZE),
        .BLOCK   (BLOCK)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s0_fire),
        .adv       (s1_adv),
        .pixel     (s0_pixel_reg),
        .info      (s0_info_reg),
        .ocol      (s0_ocol_reg),
        .sum_valid (sum_valid),
        .red_sum   (red_sum),
        .green_sum (green_sum),
        .blue_sum  (blue_sum),
        .sum_last  (sum_last)
    );

    rgbds_avg #(
        .BLOCK (BLOCK)
    ) u_avg (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (out_adv),
        .sum_valid  (sum_valid),
        .red_sum    (red_sum),
        .green_sum  (green_sum),
        .blue_sum   (blue_sum),
        .sum_last   (sum_last),
        .out_valid  (out_valid),
        .out_pixel  (out_pixel),
        .frame_last (frame_last)
    );

    // a block's bottom-right pixel always produces block totals next cycle
    `RGBDS_ASSERT(a_emit_follows, clk, rst_n,
        s0_fire && s0_info_reg.in_blk && s0_info_reg.last_col && s0_info_reg.last_row
        |=> sum_valid)

    // a stalled input register keeps its word
    `RGBDS_ASSERT(a_s0_hold, clk, rst_n,
        s0_valid_reg && !s1_adv |=> s0_valid_reg && $stable(s0_pixel_reg))

    // with the output register empty, the input side is never blocked
    `RGBDS_NEVER(a_no_false_stall, clk, rst_n, !out_valid && !in_ready)

endmodule

[design/rgbds_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module rgbds_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/rgbds_pos.sv]
// frame position tracker: input column/row and output block coordinates
// depends on rgbds_pkg
module rgbds_pos #(
    parameter int unsigned IN_SIZE = rgbds_pkg::IN_SIZE_DEF,
    parameter int unsigned BLOCK   = rgbds_pkg::BLOCK_DEF,
    localparam int unsigned OUT_SIZE = IN_SIZE / BLOCK,
    localparam int unsigned OW       = $clog2(OUT_SIZE + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    output rgbds_pkg::pos_info_t  info,
    output logic [OW-1:0]         ocol
);

    localparam int unsigned CW = $clog2(IN_SIZE);
    localparam int unsigned SW = $clog2(BLOCK);

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [SW-1:0] csub_reg, csub_next;
    logic [SW-1:0] rsub_reg, rsub_next;
    logic [OW-1:0] ocol_reg, ocol_next;
    logic [OW-1:0] orow_reg, orow_next;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        csub_next = csub_reg;
        rsub_next = rsub_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (step)
        begin
            if (col_reg == CW'(IN_SIZE - 1))
            begin
                col_next  = '0;
                csub_next = '0;
                ocol_next = '0;
                if (row_reg == CW'(IN_SIZE - 1))
                begin
                    row_next  = '0;
                    rsub_next = '0;
                    orow_next = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    if (rsub_reg == SW'(BLOCK - 1))
                    begin
                        rsub_next = '0;
                        orow_next = orow_reg + 1'b1;
                    end
                    else
                    begin
                        rsub_next = rsub_reg + 1'b1;
                    end
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                if (csub_reg == SW'(BLOCK - 1))
                begin
                    csub_next = '0;
                    ocol_next = ocol_reg + 1'b1;
                end
                else
                begin
                    csub_next = csub_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            csub_reg <= '0;
            rsub_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            csub_reg <= csub_next;
            rsub_reg <= rsub_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
        end
    end

    // trailing partial columns and rows fall outside every block
    always_comb
    begin
        info.in_blk    = (ocol_reg < OW'(OUT_SIZE)) && (orow_reg < OW'(OUT_SIZE));
        info.first_col = (csub_reg == '0);
        info.last_col  = (csub_reg == SW'(BLOCK - 1));
        info.first_row = (rsub_reg == '0);
        info.last_row  = (rsub_reg == SW'(BLOCK - 1));
        info.last_blk  = (ocol_reg == OW'(OUT_SIZE - 1)) && (orow_reg == OW'(OUT_SIZE - 1));
    end

    assign ocol = ocol_reg;

endmodule

[design/rgbds_acc.sv]
// block accumulator: row partial sums, per-column sum memory, block totals
// depends on rgbds_pkg and rgbds_ram
module rgbds_acc #(
    parameter int unsigned IN_SIZE = rgbds_pkg::IN_SIZE_DEF,
    parameter int unsigned BLOCK   = rgbds_pkg::BLOCK_DEF,
    localparam int unsigned OUT_SIZE = IN_SIZE / BLOCK,
    localparam int unsigned AREA     = BLOCK * BLOCK,
    localparam int unsigned OW       = $clog2(OUT_SIZE + 1),
    localparam int unsigned RS_W     = $clog2(rgbds_pkg::RED_MAX * AREA + 1),
    localparam int unsigned GS_W     = $clog2(rgbds_pkg::GREEN_MAX * AREA + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic                          adv,
    input  logic [rgbds_pkg::PIX_W-1:0]   pixel,
    input  rgbds_pkg::pos_info_t          info,
    input  logic [OW-1:0]                 ocol,
    output logic                          sum_valid,
    output logic [RS_W-1:0]               red_sum,
    output logic [GS_W-1:0]               green_sum,
    output logic [RS_W-1:0]               blue_sum,
    output logic                          sum_last
);

    localparam int unsigned AW   = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
    localparam int unsigned WORD = RS_W + GS_W + RS_W;

    logic [RS_W-1:0] pix_r, pix_b;
    logic [GS_W-1:0] pix_g;
    logic [RS_W-1:0] acc_r_reg, acc_b_reg;
    logic [GS_W-1:0] acc_g_reg;
    logic [RS_W-1:0] base_r, base_b, tot_r, tot_b;
    logic [GS_W-1:0] base_g, tot_g;
    logic [WORD-1:0] rd_data;
    logic            wr_en, rd_en, emit;
    logic            sum_valid_reg;
    logic [RS_W-1:0] red_sum_reg, blue_sum_reg;
    logic [GS_W-1:0] green_sum_reg;
    logic            sum_last_reg;

    assign pix_r = RS_W'(pixel[rgbds_pkg::RED_LSB +: rgbds_pkg::RED_W]);
    assign pix_g = GS_W'(pixel[rgbds_pkg::GREEN_LSB +: rgbds_pkg::GREEN_W]);
    assign pix_b = RS_W'(pixel[rgbds_pkg::BLUE_LSB +: rgbds_pkg::BLUE_W]);

    // the first row of a block starts from zero, so stale memory is never seen
    assign rd_en = fire && info.in_blk && info.first_col && !info.first_row;
    assign wr_en = fire && info.in_blk && info.last_col && !info.last_row;
    assign emit  = fire && info.in_blk && info.last_col && info.last_row;

    rgbds_ram #(
        .WIDTH (WORD),
        .DEPTH (OUT_SIZE)
    ) u_sum_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ocol[AW-1:0]),
        .wr_data ({tot_r, tot_g, tot_b}),
        .rd_en   (rd_en),
        .rd_addr (ocol[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (info.first_row)
        begin
            base_r = '0;
            base_g = '0;
            base_b = '0;
        end
        else
        begin
            base_r = rd_data[GS_W + RS_W +: RS_W];
            base_g = rd_data[RS_W +: GS_W];
            base_b = rd_data[0 +: RS_W];
        end
        tot_r = base_r + acc_r_reg + pix_r;
        tot_g = base_g + acc_g_reg + pix_g;
        tot_b = base_b + acc_b_reg + pix_b;
    end

    // horizontal partial sum within the current block row
    always_ff @(posedge clk)
    begin
        if (fire && info.in_blk)
        begin
            if (info.first_col)
            begin
                acc_r_reg <= pix_r;
                acc_g_reg <= pix_g;
                acc_b_reg <= pix_b;
            end
            else
            begin
                acc_r_reg <= acc_r_reg + pix_r;
                acc_g_reg <= acc_g_reg + pix_g;
                acc_b_reg <= acc_b_reg + pix_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sum_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            red_sum_reg   <= tot_r;
            green_sum_reg <= tot_g;
            blue_sum_reg  <= tot_b;
            sum_last_reg  <= info.last_blk;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign red_sum   = red_sum_reg;
    assign green_sum = green_sum_reg;
    assign blue_sum  = blue_sum_reg;
    assign sum_last  = sum_last_reg;

endmodule

[design/rgbds_avg.sv]
// block average: divide sums by block area via reciprocal multiply, pack rgb565
// depends on rgbds_pkg
module rgbds_avg #(
    parameter int unsigned BLOCK = rgbds_pkg::BLOCK_DEF,
    localparam int unsigned AREA = BLOCK * BLOCK,
    localparam int unsigned RS_W = $clog2(rgbds_pkg::RED_MAX * AREA + 1),
    localparam int unsigned GS_W = $clog2(rgbds_pkg::GREEN_MAX * AREA + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          sum_valid,
    input  logic [RS_W-1:0]               red_sum,
    input  logic [GS_W-1:0]               green_sum,
    input  logic [RS_W-1:0]               blue_sum,
    input  logic                          sum_last,
    output logic                          out_valid,
    output logic [rgbds_pkg::PIX_W-1:0]   out_pixel,
    output logic                          frame_last
);

    // exact floor division for every sum below 2**GS_W
    localparam int unsigned K    = GS_W + $clog2(AREA);
    localparam int unsigned RW   = K + 1;
    localparam int unsigned PW   = GS_W + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << K) + 64'(AREA) - 64'd1) / 64'(AREA));

    logic [PW-1:0] prod_r, prod_g, prod_b;
    logic [rgbds_pkg::RED_W-1:0]   q_r;
    logic [rgbds_pkg::GREEN_W-1:0] q_g;
    logic [rgbds_pkg::BLUE_W-1:0]  q_b;
    logic                          out_valid_reg;
    logic [rgbds_pkg::PIX_W-1:0]   out_pixel_reg;
    logic                          frame_last_reg;

    assign prod_r = PW'(red_sum) * PW'(RECIP);
    assign prod_g = PW'(green_sum) * PW'(RECIP);
    assign prod_b = PW'(blue_sum) * PW'(RECIP);

    assign q_r = prod_r[K +: rgbds_pkg::RED_W];
    assign q_g = prod_g[K +: rgbds_pkg::GREEN_W];
    assign q_b = prod_b[K +: rgbds_pkg::BLUE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && sum_valid)
        begin
            out_pixel_reg  <= {q_r, q_g, q_b};
            frame_last_reg <= sum_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign frame_last = frame_last_reg;

endmodule

[bench/rgbds_checker.sv]
`timescale 1ns / 1ps
// checker for the rgb565 box downsampler: watches the pixel and averaged word
// channels, predicts each block average and compares the words in order
// depends on rgbds_pkg
module rgbds_checker #(
    parameter int unsigned IN_SIZE = rgbds_pkg::IN_SIZE_DEF,
    parameter int unsigned BLOCK   = rgbds_pkg::BLOCK_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [rgbds_pkg::PIX_W-1:0] in_pixel,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [rgbds_pkg::PIX_W-1:0] out_pixel,
    input  logic                        frame_last,
    output int unsigned                 errors = 0,
    output int unsigned                 pending = 0
);

    localparam int unsigned OUT_SIZE = IN_SIZE / BLOCK;
    localparam int unsigned AREA     = BLOCK * BLOCK;

    typedef struct packed {
        logic [rgbds_pkg::PIX_W-1:0] pixel;
        logic                        last;
    } avg_word_t;

    avg_word_t   avg_words_due[$];
    int unsigned col_at;
    int unsigned row_at;
    int unsigned red_acc[OUT_SIZE];
    int unsigned green_acc[OUT_SIZE];
    int unsigned blue_acc[OUT_SIZE];

    task automatic report_mismatch(input string what,
                                   input logic [rgbds_pkg::PIX_W-1:0] got,
                                   input logic [rgbds_pkg::PIX_W-1:0] want);
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        errors++;
    endtask

    // adds one pixel to its column sums; returns 1 when it closes a block
    function automatic logic accumulate_pixel(input logic [rgbds_pkg::PIX_W-1:0] pix,
                                              output avg_word_t word);
        int unsigned                     ocol;
        int unsigned                     orow;
        int unsigned                     quot;
        logic [rgbds_pkg::RED_W-1:0]     red_avg;
        logic [rgbds_pkg::GREEN_W-1:0]   green_avg;
        logic [rgbds_pkg::BLUE_W-1:0]    blue_avg;
        logic                            emit;
        ocol = col_at / BLOCK;
        orow = row_at / BLOCK;
        emit = 1'b0;
        word = '0;
        // pixels of a trailing partial block are dropped
        if (ocol < OUT_SIZE && orow < OUT_SIZE)
        begin
            red_acc[ocol]   += pix[rgbds_pkg::RED_LSB +: rgbds_pkg::RED_W];
            green_acc[ocol] += pix[rgbds_pkg::GREEN_LSB +: rgbds_pkg::GREEN_W];
            blue_acc[ocol]  += pix[rgbds_pkg::BLUE_LSB +: rgbds_pkg::BLUE_W];
            if (col_at % BLOCK == BLOCK - 1 && row_at % BLOCK == BLOCK - 1)
            begin
                quot = red_acc[ocol] / AREA;
                red_avg = quot[rgbds_pkg::RED_W-1:0];
                quot = green_acc[ocol] / AREA;
                green_avg = quot[rgbds_pkg::GREEN_W-1:0];
                quot = blue_acc[ocol] / AREA;
                blue_avg = quot[rgbds_pkg::BLUE_W-1:0];
                word.pixel[rgbds_pkg::RED_LSB +: rgbds_pkg::RED_W]     = red_avg;
                word.pixel[rgbds_pkg::GREEN_LSB +: rgbds_pkg::GREEN_W] = green_avg;
                word.pixel[rgbds_pkg::BLUE_LSB +: rgbds_pkg::BLUE_W]   = blue_avg;
                word.last = (ocol == OUT_SIZE - 1) && (orow == OUT_SIZE - 1);
                red_acc[ocol]   = 0;
                green_acc[ocol] = 0;
                blue_acc[ocol]  = 0;
                emit = 1'b1;
            end
        end
        // raster position, wrapping at the end of the frame
        col_at++;
        if (col_at >= IN_SIZE)
        begin
            col_at = 0;
            row_at++;
            if (row_at >= IN_SIZE)
                row_at = 0;
        end
        return emit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        avg_word_t fresh;
        avg_word_t want;
        if (!rst_n)
        begin
            avg_words_due.delete();
            col_at = 0;
            row_at = 0;
            for (int i = 0; i < OUT_SIZE; i++)
            begin
                red_acc[i]   = 0;
                green_acc[i] = 0;
                blue_acc[i]  = 0;
            end
            pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (accumulate_pixel(in_pixel, fresh))
                    avg_words_due.push_back(fresh);
            end
            if (out_valid && out_ready)
            begin
                if (avg_words_due.size() == 0)
                    report_mismatch("averaged word with none due", out_pixel, '0);
                else
                begin
                    want = avg_words_due.pop_front();
                    if (out_pixel !== want.pixel)
                        report_mismatch("out_pixel", out_pixel, want.pixel);
                    if (frame_last !== want.last)
                        report_mismatch("frame_last", rgbds_pkg::PIX_W'(frame_last),
                                        rgbds_pkg::PIX_W'(want.last));
                end
            end
            pending <= avg_words_due.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// testbench top for the rgb565 box downsampler: clock, reset, pixel words
// and output backpressure; the verdict comes from rgbds_checker
// depends on rgbds_pkg, rgb565_box_downsampler_top, rgbds_checker
module tb_top;

    localparam int unsigned FRAME_SIZE   = rgbds_pkg::IN_SIZE_DEF;
    localparam int unsigned BLK_SIZE     = rgbds_pkg::BLOCK_DEF;
    localparam int unsigned BAND_WORDS   = FRAME_SIZE * BLK_SIZE;
    // seven full block rows of the frame
    localparam int unsigned TOTAL_WORDS  = 7 * BAND_WORDS;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CALM_FROM    = 800;
    localparam int unsigned CALM_TO      = 1300;
    localparam int unsigned IDLE_PCT     = 31;

    localparam logic [rgbds_pkg::PIX_W-1:0] RED_ONLY =
        rgbds_pkg::PIX_W'(rgbds_pkg::RED_MAX << rgbds_pkg::RED_LSB);
    localparam logic [rgbds_pkg::PIX_W-1:0] GREEN_ONLY =
        rgbds_pkg::PIX_W'(rgbds_pkg::GREEN_MAX << rgbds_pkg::GREEN_LSB);
    localparam logic [rgbds_pkg::PIX_W-1:0] BLUE_ONLY =
        rgbds_pkg::PIX_W'(((1 << rgbds_pkg::BLUE_W) - 1) << rgbds_pkg::BLUE_LSB);

    localparam logic [rgbds_pkg::PIX_W-1:0] EDGE_PIXELS [0:15] = '{
        16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h0821, 16'h8410, 16'h7BEF,
        16'h8000, 16'h0001, 16'hAAAA, 16'h5555, 16'hF81F, 16'hFFE0, 16'h07FF, 16'h0000
    };

    // content style of one band of block rows
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_WHITE,
        FILL_BLACK,
        FILL_EXTREME
    } band_fill_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [rgbds_pkg::PIX_W-1:0] in_pixel = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [rgbds_pkg::PIX_W-1:0] out_pixel;
    logic                        frame_last;

    int unsigned words_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned errors;
    int unsigned pending;
    int unsigned fill_band = '1;
    band_fill_t  fill = FILL_RANDOM;
    logic        calm;

    rgb565_box_downsampler_top #(
        .IN_SIZE (FRAME_SIZE),
        .BLOCK   (BLK_SIZE)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_pixel   (in_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_pixel  (out_pixel),
        .frame_last (frame_last)
    );

    rgbds_checker #(
        .IN_SIZE (FRAME_SIZE),
        .BLOCK   (BLK_SIZE)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_pixel   (in_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_pixel  (out_pixel),
        .frame_last (frame_last),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // no idling on either side inside this window
    assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    // pixel word n: edge values first, then bands of block rows with one fill each
    function automatic logic [rgbds_pkg::PIX_W-1:0] next_pixel(input int unsigned n);
        int unsigned                 band;
        int unsigned                 roll;
        logic [rgbds_pkg::PIX_W-1:0] pick;
        if (n < $size(EDGE_PIXELS))
            return EDGE_PIXELS[n];
        band = n / BAND_WORDS;
        if (band != fill_band)
        begin
            fill_band = band;
            roll = $urandom_range(99);
            if (roll < 55)
                fill = FILL_RANDOM;
            else if (roll < 70)
                fill = FILL_WHITE;
            else if (roll < 82)
                fill = FILL_BLACK;
            else
                fill = FILL_EXTREME;
        end
        case (fill)
            FILL_WHITE:  pick = '1;
            FILL_BLACK:  pick = '0;
            FILL_EXTREME:
            begin
                case ($urandom_range(4))
                    0:       pick = '0;
                    1:       pick = '1;
                    2:       pick = RED_ONLY;
                    3:       pick = GREEN_ONLY;
                    default: pick = BLUE_ONLY;
                endcase
            end
            default:     pick = rgbds_pkg::PIX_W'($urandom());
        endcase
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_pixel   <= '0;
            words_sent <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (words_sent < TOTAL_WORDS && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                in_valid   <= 1'b1;
                in_pixel   <= next_pixel(words_sent);
                words_sent <= words_sent + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (words_sent < TOTAL_WORDS || in_valid)
            @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
